### hdl/fractional_shift_cubic_resampler_top_macros.svh
// assertion macros for the fractional shift cubic resampler
`ifndef FRACTIONAL_SHIFT_CUBIC_RESAMPLER_TOP_MACROS_SVH
`define FRACTIONAL_SHIFT_CUBIC_RESAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define FSCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fscr_pkg.sv
// shared types and constants of the fractional shift cubic resampler
`default_nettype none
package fscr_pkg;

  localparam int MAX_BINS        = 256;
  localparam int MAX_CHANNELS    = 2;
  localparam int SAMPLE_BITS     = 16;
  localparam int SHIFT_FRAC_BITS = 8;

  localparam int BIN_BITS     = $clog2(MAX_BINS);
  localparam int CH_BITS      = 1;
  localparam int SHIFT_BITS   = BIN_BITS + SHIFT_FRAC_BITS + 1;
  localparam int ADDR_BITS    = CH_BITS + BIN_BITS;
  localparam int STORE_DEPTH  = MAX_BINS * MAX_CHANNELS;
  localparam int TAPS         = 4;
  localparam int NBINS_BITS   = 9;
  localparam int NEVEN_BITS   = NBINS_BITS + 1;
  localparam int NCH_BITS     = 2;
  localparam int CFG_IDX_BITS = 2;

  // signed index arithmetic and cubic datapath widths
  localparam int POS_W     = BIN_BITS + 4;
  localparam int COEF_W    = SAMPLE_BITS + 4;
  localparam int A0_W      = SAMPLE_BITS + 3;
  localparam int A1_W      = SAMPLE_BITS + 4;
  localparam int A2_W      = SAMPLE_BITS + 1;
  localparam int T1_W      = A1_W + SHIFT_FRAC_BITS + 1;
  localparam int T2_W      = T1_W + SHIFT_FRAC_BITS;
  localparam int T3_W      = T2_W + SHIFT_FRAC_BITS;
  localparam int RES_SHIFT = 3 * SHIFT_FRAC_BITS + 1;
  localparam int SUM_W     = T3_W - RES_SHIFT + 1;

  localparam logic [NBINS_BITS-1:0] BINS_RESET  = NBINS_BITS'(256);
  localparam logic [NCH_BITS-1:0]   CHANS_RESET = NCH_BITS'(1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_BINS     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = CFG_IDX_BITS'(1);

  localparam logic signed [POS_W-1:0] POS_ZERO  = POS_W'(0);
  localparam logic signed [POS_W-1:0] POS_ONE   = POS_W'(1);
  localparam logic signed [POS_W-1:0] POS_THREE = POS_W'(3);

  localparam logic signed [T3_W-1:0] ROUND_HALF = T3_W'(64'd1 << (3 * SHIFT_FRAC_BITS));

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_t;

  typedef struct packed {
    logic                              mode;
    logic [CH_BITS-1:0]                ch;
    logic [BIN_BITS-1:0]               bin;
    logic signed [SAMPLE_BITS-1:0]     sample;
    logic signed [SHIFT_BITS-1:0]      shift;
  } req_t;

  typedef struct packed {
    logic [CH_BITS-1:0]         ch;
    logic [BIN_BITS-1:0]        bin;
    logic                       err;
    logic                       at_edge;
    logic [SHIFT_FRAC_BITS-1:0] frac;
  } side_t;

endpackage
`default_nettype wire

### hdl/fractional_shift_cubic_resampler_top.sv
// top level of the fractional shift cubic resampler
// a query result passes through stages a to g and the output register before it is presented
// loads are written to the store at the second stage and give no result
// one request per cycle unless stalled; four store copies give all neighbours at once
// reset: clears all stage valid bits and sets 256 bins and 1 channel
// the sample store is not cleared by reset
`default_nettype none
module fractional_shift_cubic_resampler_top
  import fscr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [CH_BITS-1:0]            channel,
  input  logic [BIN_BITS-1:0]           bin,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [SHIFT_BITS-1:0]  shift_q8,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [CH_BITS-1:0]            out_channel,
  output logic [BIN_BITS-1:0]           out_bin,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [NBINS_BITS-1:0]         cfg_data
);

  logic [NBINS_BITS-1:0] bins_cfg;
  logic [NCH_BITS-1:0]   chans_cfg;
  logic [NEVEN_BITS-1:0] bins_even;
  logic [NBINS_BITS-1:0] n_eff;
  logic [NCH_BITS-1:0]   nch_eff;

  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_o;
  logic a_valid, b_valid, c_valid, d_valid, e_valid, f_valid, g_valid;

  req_t a_req;

  logic signed [SHIFT_BITS:0]     neg_shift;
  logic signed [POS_W-1:0]        c_a, n_s, nm1_s, bin_s, start_s, end_s, base_s, tap_s;
  logic                           hi_a, lo_a;
  side_t                          side_a;
  logic [ADDR_BITS-1:0]           raddr_a [TAPS];

  logic                           b_query;
  side_t                          side_b;
  logic [ADDR_BITS-1:0]           b_waddr;
  logic signed [SAMPLE_BITS-1:0]  b_sample;
  logic [ADDR_BITS-1:0]           b_raddr [TAPS];

  logic signed [SAMPLE_BITS-1:0]  store [TAPS][STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0]  y_c [TAPS];
  side_t                          side_c;

  logic signed [COEF_W-1:0]       e0, e1, e2, e3, a0_full, a1_full, a2_full;
  logic signed [A0_W-1:0]         a0_d;
  logic signed [A1_W-1:0]         a1_d;
  logic signed [A2_W-1:0]         a2_d, a2_e;
  logic signed [SAMPLE_BITS-1:0]  y1_d, y1_e, y1_f, y1_g;
  side_t                          side_d, side_e, side_f, side_g;

  logic signed [SHIFT_FRAC_BITS:0] fs_d, fs_e, fs_f;
  logic signed [T1_W-1:0]         t1_next, t1_e;
  logic signed [T2_W-1:0]         t2_next, t2_f;
  logic signed [T3_W-1:0]         t3_next, t3_g, t3_sh;
  logic signed [SUM_W-1:0]        sum_g;
  logic signed [SAMPLE_BITS-1:0]  val_next;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_cfg  <= BINS_RESET;
      chans_cfg <= CHANS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BINS) begin
        bins_cfg <= cfg_data;
      end else if (cfg_index == CFG_CHANNELS) begin
        chans_cfg <= cfg_data[NCH_BITS-1:0];
      end
    end
  end

  always_comb begin
    bins_even = {1'b0, bins_cfg} + NEVEN_BITS'(bins_cfg[0]);
    priority if (bins_cfg < NBINS_BITS'(2)) begin
      n_eff = NBINS_BITS'(2);
    end else if (bins_even > NEVEN_BITS'(MAX_BINS)) begin
      n_eff = NBINS_BITS'(MAX_BINS);
    end else begin
      n_eff = bins_even[NBINS_BITS-1:0];
    end
    nch_eff = (chans_cfg > NCH_BITS'(MAX_CHANNELS)) ? NCH_BITS'(MAX_CHANNELS) : chans_cfg;
  end

  // stage enables, bubbles collapse
  assign en_o     = !out_valid || !out_stall;
  assign en_g     = !g_valid || en_o;
  assign en_f     = !f_valid || en_g;
  assign en_e     = !e_valid || en_f;
  assign en_d     = !d_valid || en_e;
  assign en_c     = !c_valid || en_d;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid && b_query;
      if (en_d) d_valid <= c_valid;
      if (en_e) e_valid <= d_valid;
      if (en_f) f_valid <= e_valid;
      if (en_g) g_valid <= f_valid;
      if (en_o) out_valid <= g_valid;
    end
  end

  // stage a: request capture
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_req.mode   <= mode;
      a_req.ch     <= channel;
      a_req.bin    <= bin;
      a_req.sample <= sample_in;
      a_req.shift  <= shift_q8;
    end
  end

  // shift split, region and neighbour addresses
  always_comb begin
    neg_shift = -(SHIFT_BITS + 1)'(a_req.shift);
    c_a       = POS_W'(neg_shift >>> SHIFT_FRAC_BITS);
    n_s       = POS_W'(n_eff);
    nm1_s     = n_s - POS_ONE;
    bin_s     = POS_W'(a_req.bin);

    start_s = POS_ONE - c_a;
    if (start_s < POS_ZERO) start_s = POS_ZERO;
    if (start_s > nm1_s) start_s = nm1_s;
    end_s = n_s - c_a - POS_THREE;
    if (end_s > n_s) end_s = n_s;
    if (end_s < POS_ONE) end_s = POS_ONE;

    hi_a   = bin_s >= end_s;
    lo_a   = bin_s < start_s;
    base_s = bin_s + c_a - POS_ONE;

    tap_s = POS_ZERO;
    for (int k = 0; k < TAPS; k++) begin
      tap_s = base_s + POS_W'(k);
      if (tap_s < POS_ZERO) tap_s = POS_ZERO;
      if (tap_s > nm1_s) tap_s = nm1_s;
      raddr_a[k] = {a_req.ch, tap_s[BIN_BITS-1:0]};
    end
    // edge regions read the end sample into the centre tap
    priority if (hi_a) begin
      raddr_a[1] = {a_req.ch, nm1_s[BIN_BITS-1:0]};
    end else if (lo_a) begin
      raddr_a[1] = {a_req.ch, {BIN_BITS{1'b0}}};
    end else begin
      raddr_a[1] = raddr_a[1];
    end

    side_a.ch      = a_req.ch;
    side_a.bin     = a_req.bin;
    side_a.err     = ({1'b0, a_req.ch} >= nch_eff) || ({1'b0, a_req.bin} >= n_eff);
    side_a.at_edge = hi_a || lo_a;
    side_a.frac    = neg_shift[SHIFT_FRAC_BITS-1:0];
  end

  // stage b
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_query  <= (a_req.mode == MODE_QUERY);
      side_b   <= side_a;
      b_waddr  <= {a_req.ch, a_req.bin};
      b_sample <= a_req.sample;
      b_raddr  <= raddr_a;
    end
  end

  // sample store, one copy per neighbour tap
  always_ff @(posedge clk) begin
    if (en_c) begin
      for (int k = 0; k < TAPS; k++) begin
        if (b_valid && !b_query) begin
          store[k][b_waddr] <= b_sample;
        end
        y_c[k] <= store[k][b_raddr[k]];
      end
      side_c <= side_b;
    end
  end

  // stage d: cubic coefficients
  always_comb begin
    e0      = COEF_W'(y_c[0]);
    e1      = COEF_W'(y_c[1]);
    e2      = COEF_W'(y_c[2]);
    e3      = COEF_W'(y_c[3]);
    a0_full = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
    a1_full = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    a2_full = e2 - e0;
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      a0_d   <= a0_full[A0_W-1:0];
      a1_d   <= a1_full[A1_W-1:0];
      a2_d   <= a2_full[A2_W-1:0];
      y1_d   <= y_c[1];
      side_d <= side_c;
    end
  end

  // horner steps, one multiply by the fraction per stage
  assign fs_d    = signed'({1'b0, side_d.frac});
  assign fs_e    = signed'({1'b0, side_e.frac});
  assign fs_f    = signed'({1'b0, side_f.frac});
  assign t1_next = T1_W'(a0_d) * T1_W'(fs_d) + (T1_W'(a1_d) <<< SHIFT_FRAC_BITS);
  assign t2_next = T2_W'(t1_e) * T2_W'(fs_e) + (T2_W'(a2_e) <<< (2 * SHIFT_FRAC_BITS));
  assign t3_next = T3_W'(t2_f) * T3_W'(fs_f) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en_e) begin
      t1_e   <= t1_next;
      a2_e   <= a2_d;
      y1_e   <= y1_d;
      side_e <= side_d;
    end
    if (en_f) begin
      t2_f   <= t2_next;
      y1_f   <= y1_e;
      side_f <= side_e;
    end
    if (en_g) begin
      t3_g   <= t3_next;
      y1_g   <= y1_f;
      side_g <= side_f;
    end
  end

  // final rounding, saturation and result select
  always_comb begin
    t3_sh = t3_g >>> RES_SHIFT;
    sum_g = SUM_W'(y1_g) + SUM_W'(t3_sh);
    priority if (side_g.err) begin
      val_next = '0;
    end else if (side_g.at_edge) begin
      val_next = y1_g;
    end else if (sum_g > SUM_W'(SAMPLE_MAX)) begin
      val_next = SAMPLE_MAX;
    end else if (sum_g < SUM_W'(SAMPLE_MIN)) begin
      val_next = SAMPLE_MIN;
    end else begin
      val_next = sum_g[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      value       <= val_next;
      out_channel <= side_g.ch;
      out_bin     <= side_g.bin;
      status      <= side_g.err ? STATUS_RANGE : STATUS_OK;
    end
  end

endmodule
`default_nettype wire

### hdl/fscr_checker.sv
// port-level assertions for the fractional shift cubic resampler
`default_nettype none
`include "fractional_shift_cubic_resampler_top_macros.svh"
module fscr_checker
  import fscr_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] value,
  input logic [CH_BITS-1:0]            out_channel,
  input logic [BIN_BITS-1:0]           out_bin,
  input logic                          status
);

  // a free output register lets every stage move
  `FSCR_ASSERT_NOW(a_open_when_drained, clk, rst, !(out_valid && out_stall), !in_stall, "request stalled while output can move")

  // out of range requests give a zero value
  `FSCR_ASSERT_NOW(a_range_zero, clk, rst, out_valid && (status == STATUS_RANGE), value == '0, "range error with nonzero value")

  // a stalled result holds
  `FSCR_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(value) && $stable(out_channel) && $stable(out_bin) && $stable(status), "stalled result changed")

endmodule

bind fractional_shift_cubic_resampler_top fscr_checker u_checker (.*);
`default_nettype wire

### test/shifted_sample_checker.sv
// checker for the cubic resampler: predicts each shifted sample and compares the results
`timescale 1ns / 1ps
module shifted_sample_checker
  import fscr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          mode,
  input  logic [CH_BITS-1:0]            channel,
  input  logic [BIN_BITS-1:0]           bin,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [SHIFT_BITS-1:0]  shift_q8,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] value,
  input  logic [CH_BITS-1:0]            out_channel,
  input  logic [BIN_BITS-1:0]           out_bin,
  input  logic                          status,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [NBINS_BITS-1:0]         cfg_data,
  output int                            results_pending,
  output int                            failures
);

  localparam longint FRAC_ONE = longint'(1) <<< SHIFT_FRAC_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CH_BITS-1:0]            ch;
    logic [BIN_BITS-1:0]           bin;
    status_t                       status;
  } shifted_sample_t;

  logic signed [SAMPLE_BITS-1:0] wave_store [STORE_DEPTH];
  logic [NBINS_BITS-1:0]         bins_reg  = BINS_RESET;
  logic [NCH_BITS-1:0]           chans_reg = CHANS_RESET;
  shifted_sample_t               due_samples [$];
  int                            fail_count = 0;

  // neighbour fetch, clamped to the waveform ends
  function automatic longint wave_at(int ch, longint idx, int n);
    if (idx < 0) idx = 0;
    if (idx > n - 1) idx = n - 1;
    return longint'(wave_store[ch * MAX_BINS + idx]);
  endfunction

  function automatic longint cubic_between(longint y0, longint y1, longint y2, longint y3,
                                           longint f);
    longint a0, a1, a2, acc;
    a0 = -y0 + 3 * y1 - 3 * y2 + y3;
    a1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    a2 = y2 - y0;
    acc = a0 * f * f * f + a1 * f * f * FRAC_ONE + a2 * f * FRAC_ONE * FRAC_ONE
        + (longint'(1) <<< (3 * SHIFT_FRAC_BITS));
    return y1 + (acc >>> (3 * SHIFT_FRAC_BITS + 1));
  endfunction

  function automatic shifted_sample_t predict_shifted_sample(logic [CH_BITS-1:0] ch,
                                                             logic [BIN_BITS-1:0] b,
                                                             logic signed [SHIFT_BITS-1:0] sh);
    shifted_sample_t r;
    int n, nch;
    longint s, f, c, first_bin, last_bin, bl, pos, v;
    n = int'(bins_reg);
    if (n < 2) n = 2;
    if (n % 2 != 0) n++;
    if (n > MAX_BINS) n = MAX_BINS;
    nch = int'(chans_reg);
    if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
    r.value = '0;
    r.ch = ch;
    r.bin = b;
    r.status = STATUS_OK;
    bl = longint'(b);
    if (int'(ch) >= nch || bl >= n) begin
      r.status = STATUS_RANGE;
      return r;
    end
    s = -longint'(sh);
    f = s & (FRAC_ONE - 1);
    c = (s - f) >>> SHIFT_FRAC_BITS;
    first_bin = 1 - c;
    if (first_bin < 0) first_bin = 0;
    if (first_bin > n - 1) first_bin = n - 1;
    last_bin = n - c - 3;
    if (last_bin > n) last_bin = n;
    if (last_bin < 1) last_bin = 1;
    if (bl >= last_bin) begin
      v = wave_at(ch, n - 1, n);
    end else if (bl < first_bin) begin
      v = wave_at(ch, 0, n);
    end else begin
      pos = bl + c - 1;
      v = cubic_between(wave_at(ch, pos, n), wave_at(ch, pos + 1, n),
                        wave_at(ch, pos + 2, n), wave_at(ch, pos + 3, n), f);
    end
    if (v > longint'(SAMPLE_MAX)) v = longint'(SAMPLE_MAX);
    if (v < longint'(SAMPLE_MIN)) v = longint'(SAMPLE_MIN);
    r.value = SAMPLE_BITS'(v);
    return r;
  endfunction

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    shifted_sample_t due;
    if (rst) begin
      bins_reg = BINS_RESET;
      chans_reg = CHANS_RESET;
      due_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_samples.size() == 0) begin
          $display("%0t unexpected result: expected none, actual channel %0d bin %0d value %0d",
                   $time, out_channel, out_bin, value);
          fail_count++;
        end else begin
          due = due_samples.pop_front();
          check_field("value", due.value, value);
          check_field("out_channel", due.ch, out_channel);
          check_field("out_bin", due.bin, out_bin);
          check_field("status", due.status, status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BINS) bins_reg = cfg_data;
        else if (cfg_index == CFG_CHANNELS) chans_reg = cfg_data[NCH_BITS-1:0];
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_LOAD) wave_store[{channel, bin}] = sample_in;
        else due_samples.push_back(predict_shifted_sample(channel, bin, shift_q8));
      end
    end
    results_pending <= due_samples.size();
    failures <= fail_count;
  end

endmodule

### test/testbench.sv
// testbench top: reset, configuration, request stimulus and verdict for the cubic resampler
`timescale 1ns / 1ps
module testbench;
  import fscr_pkg::*;

  localparam int PHASES           = 10;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int DRAIN_CYCLES     = 12;
  localparam int LONG_HOLD        = 90;
  localparam int QUIET_LIMIT      = 2000;

  typedef enum logic [2:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_HOLD
  } stall_pattern_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          mode = 1'b0;
  logic [CH_BITS-1:0]            channel = '0;
  logic [BIN_BITS-1:0]           bin = '0;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic signed [SHIFT_BITS-1:0]  shift_q8 = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] value;
  logic [CH_BITS-1:0]            out_channel;
  logic [BIN_BITS-1:0]           out_bin;
  logic                          status;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [NBINS_BITS-1:0]         cfg_data = '0;
  int                            results_pending;
  int                            failures;

  int             burst_left = 0;
  int             max_gap = 3;
  stall_pattern_t stall_mode = STALL_LIGHT;
  int             hold_count = 0;
  int             tick = 0;
  int             quiet_cycles = 0;

  int             phase_bins  [PHASES] = '{256, 2, 5, 1, 511, 300, 37, 0, 0, 0};
  int             phase_chans [PHASES] = '{2, 2, 2, 3, 2, 0, 1, 2, 2, 0};
  int             phase_gap   [PHASES] = '{0, 4, 10, 6, 0, 3, 8, 2, 2, 5};
  stall_pattern_t phase_stall [PHASES] = '{STALL_HOLD, STALL_LIGHT, STALL_HEAVY,
                                           STALL_PERIODIC, STALL_NONE, STALL_LIGHT,
                                           STALL_HEAVY, STALL_PERIODIC, STALL_LIGHT,
                                           STALL_PERIODIC};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fractional_shift_cubic_resampler_top DUT (.*);

  shifted_sample_checker checker_inst (.*);

  // receiver stall patterns, one long hold to fill the pipeline
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      tick++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(99) < 25);
        STALL_HEAVY:    out_stall <= ($urandom_range(99) < 70);
        STALL_PERIODIC: out_stall <= ((tick % 7) >= 4);
        STALL_HOLD: begin
          if (hold_count < LONG_HOLD) begin
            out_stall <= 1'b1;
            hold_count++;
          end else begin
            out_stall <= ($urandom_range(99) < 25);
          end
        end
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_request(mode_t m, logic [CH_BITS-1:0] ch, logic [BIN_BITS-1:0] b,
                              logic signed [SAMPLE_BITS-1:0] smp,
                              logic signed [SHIFT_BITS-1:0] sh);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    mode <= m;
    channel <= ch;
    bin <= b;
    sample_in <= smp;
    shift_q8 <= sh;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic send_random_item(int span);
    int roll, pick;
    logic [BIN_BITS-1:0] b;
    logic signed [SHIFT_BITS-1:0] sh;
    roll = $urandom_range(99);
    b = ($urandom_range(99) < 85) ? BIN_BITS'($urandom_range(span - 1)) : BIN_BITS'($urandom);
    if (roll < 25) begin
      send_request(MODE_LOAD, CH_BITS'($urandom), b, pick_sample(), SHIFT_BITS'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) sh = SHIFT_BITS'(int'($urandom_range(4096)) - 2048);
      else if (pick < 80) sh = SHIFT_BITS'(int'($urandom_range(2 * span * 256)) - span * 256);
      else sh = SHIFT_BITS'($urandom);
      send_request(MODE_QUERY, CH_BITS'($urandom), b, SAMPLE_BITS'($urandom), sh);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [NBINS_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int bins_cfg, chans_cfg, span;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // fill both waveforms so no query reads an empty entry
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      for (int b = 0; b < MAX_BINS; b++) begin
        send_request(MODE_LOAD, CH_BITS'(ch), BIN_BITS'(b), pick_sample(),
                     SHIFT_BITS'($urandom));
      end
    end

    // overshoot to full scale, read straight after the writes
    send_request(MODE_LOAD, 0, 20, SAMPLE_MIN, 0);
    send_request(MODE_LOAD, 0, 21, SAMPLE_MAX, 0);
    send_request(MODE_LOAD, 0, 22, SAMPLE_MAX, 0);
    send_request(MODE_LOAD, 0, 23, SAMPLE_MIN, 0);
    send_request(MODE_QUERY, 0, 21, 0, -128);
    send_request(MODE_LOAD, 0, 30, SAMPLE_MAX, 0);
    send_request(MODE_LOAD, 0, 31, SAMPLE_MIN, 0);
    send_request(MODE_LOAD, 0, 32, SAMPLE_MIN, 0);
    send_request(MODE_LOAD, 0, 33, SAMPLE_MAX, 0);
    send_request(MODE_QUERY, 0, 31, 0, -128);
    // edges of the waveform and of the shift range
    send_request(MODE_QUERY, 0, 0, 0, 0);
    send_request(MODE_QUERY, 0, 255, 0, 0);
    send_request(MODE_QUERY, 0, 128, SAMPLE_MAX, 65535);
    send_request(MODE_QUERY, 0, 128, SAMPLE_MIN, -65536);
    send_request(MODE_QUERY, 0, 5, 0, 256);
    send_request(MODE_QUERY, 0, 5, 0, -1);
    send_request(MODE_QUERY, 0, 254, 0, -256);
    send_request(MODE_QUERY, 0, 1, 0, 1);
    // channel not in use
    send_request(MODE_QUERY, 1, 10, 0, 0);
    send_request(MODE_LOAD, 1, 255, 1, 0);

    for (int p = 0; p < PHASES; p++) begin
      bins_cfg = phase_bins[p];
      chans_cfg = phase_chans[p];
      if (p == PHASES - 3) bins_cfg = 2 * $urandom_range(1, 128);
      if (p == PHASES - 1) begin
        bins_cfg = $urandom_range(0, 511);
        chans_cfg = $urandom_range(0, 3);
      end
      wait_idle();
      cfg_write(CFG_BINS, NBINS_BITS'(bins_cfg));
      cfg_write(CFG_CHANNELS, {7'($urandom), 2'(chans_cfg)});
      span = (bins_cfg < 2) ? 2 : bins_cfg;
      if (span % 2 != 0) span++;
      if (span > MAX_BINS) span = MAX_BINS;
      stall_mode <= phase_stall[p];
      max_gap = phase_gap[p];
      repeat (RANDOM_PER_PHASE) send_random_item(span);
    end

    wait_idle();
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
